/* hw/rtl/lfuc_pkg.sv */
// Shared types and constants for the LFU cache table.
// No dependencies; every other file in hw/rtl refers to this package by scoped name.
package lfuc_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KEY_W = 32;
   localparam int VAL_W = 31;
   localparam int CNT_W = 32;
   localparam int CFG_W = 5;

   localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [CNT_W-1:0] COUNT_ONE = 32'd1;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Sequencer to scan unit
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

   // Scan unit to sequencer
   typedef struct packed {
      logic match;
      logic free;
      logic victim;
   } scan_flags_type;

endpackage

/* hw/rtl/lfuc_ifs.sv */
// Valid/ready channel interfaces for the LFU cache table: request and response.
// Depends on lfuc_pkg for field widths.
interface lfuc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [lfuc_pkg::KEY_W-1:0]  key;
   logic [lfuc_pkg::VAL_W-1:0]  value;

   modport source (output valid, command, key, value, input ready);
   modport sink   (input valid, command, key, value, output ready);
endinterface

interface lfuc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [lfuc_pkg::VAL_W-1:0]  read_value;
   logic                        evicted;

   modport source (output valid, hit, read_value, evicted, input ready);
   modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

/* hw/rtl/lfuc_scan_unit.sv */
// Shared compare unit of the LFU cache table: tracks key match, first free slot
// and LFU/LRU victim over one entry per cycle. Depends on lfuc_pkg.
module lfuc_scan_unit #(
   parameter  int CAPACITY = lfuc_pkg::DEPTH_DEFAULT,
   localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lfuc_pkg::scan_ctl_type      ctl,
   input  logic [IW-1:0]               smp_idx,
   input  logic                        smp_valid,
   input  logic [lfuc_pkg::KEY_W-1:0]  smp_key,
   input  logic [lfuc_pkg::KEY_W-1:0]  req_key,
   input  logic [lfuc_pkg::VAL_W-1:0]  smp_value,
   input  logic [lfuc_pkg::CNT_W-1:0]  smp_count,
   input  logic [IW-1:0]               smp_rank,
   output lfuc_pkg::scan_flags_type    flags,
   output logic [IW-1:0]               match_idx,
   output logic [lfuc_pkg::VAL_W-1:0]  match_value,
   output logic [lfuc_pkg::CNT_W-1:0]  match_count,
   output logic [IW-1:0]               match_rank,
   output logic [IW-1:0]               free_idx,
   output logic [IW-1:0]               victim_idx,
   output logic [IW-1:0]               victim_rank
);

   lfuc_pkg::scan_flags_type   flags_ff;
   logic [IW-1:0]              match_idx_ff;
   logic [lfuc_pkg::VAL_W-1:0] match_value_ff;
   logic [lfuc_pkg::CNT_W-1:0] match_count_ff;
   logic [IW-1:0]              match_rank_ff;
   logic [IW-1:0]              free_idx_ff;
   logic [IW-1:0]              victim_idx_ff;
   logic [IW-1:0]              victim_rank_ff;
   logic [lfuc_pkg::CNT_W-1:0] victim_count_ff;

   logic take_match;
   logic take_free;
   logic take_victim;

   always_comb begin
      take_match  = ctl.sample && smp_valid && (smp_key == req_key) && !flags_ff.match;
      take_free   = ctl.sample && !smp_valid && !flags_ff.free;
      // Smaller count wins; on equal counts the older entry (larger rank) wins
      take_victim = ctl.sample && smp_valid &&
                    (!flags_ff.victim || (smp_count < victim_count_ff) ||
                     ((smp_count == victim_count_ff) && (smp_rank > victim_rank_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         flags_ff <= '0;
      end else begin
         if (take_match) begin
            flags_ff.match <= 1'b1;
         end
         if (take_free) begin
            flags_ff.free <= 1'b1;
         end
         if (take_victim) begin
            flags_ff.victim <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_match) begin
         match_idx_ff   <= smp_idx;
         match_value_ff <= smp_value;
         match_count_ff <= smp_count;
         match_rank_ff  <= smp_rank;
      end
      if (take_free) begin
         free_idx_ff <= smp_idx;
      end
      if (take_victim) begin
         victim_idx_ff   <= smp_idx;
         victim_rank_ff  <= smp_rank;
         victim_count_ff <= smp_count;
      end
   end

   assign flags       = flags_ff;
   assign match_idx   = match_idx_ff;
   assign match_value = match_value_ff;
   assign match_count = match_count_ff;
   assign match_rank  = match_rank_ff;
   assign free_idx    = free_idx_ff;
   assign victim_idx  = victim_idx_ff;
   assign victim_rank = victim_rank_ff;

endmodule

/* hw/rtl/lfu_cache_table.sv */
// Top level of the LFU cache table: sequencer, entry memories and result register.
// Depends on lfuc_pkg, lfuc_ifs (lfuc_req_if, lfuc_rsp_if) and lfuc_scan_unit.
//
// Usage
//   req_chan carries one transaction per get (command 0) or put (command 1) with a
//   32-bit key and a 31-bit value. rsp_chan returns exactly one transaction per
//   request: hit, read_value (get hit only, else 0) and evicted (put that replaced
//   an entry). csr_wr_en/csr_wr_data set capacity_in_use; write only when idle.
// Timing
//   Each request walks every entry once through the shared compare unit, one
//   entry per cycle over the single read port of the entry memories. The result
//   is loaded when the sequencer leaves its done state, and req_chan.ready returns
//   high in that same cycle; that commit waits while an older response is held.
//   Recency ranks are aged lazily: the update left by one request is written
//   back during the scan of the next one.
// Reset
//   Synchronous, active high. Clears valid marks, fill count and response valid,
//   and sets capacity_in_use to 16. No clearing pass is needed.
// Backpressure
//   The result register holds a finished response while rsp_chan.ready is low;
//   a new request is still taken and scanned, and its commit waits for the slot.
module lfu_cache_table #(
   parameter int CAPACITY = lfuc_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   lfuc_req_if.sink                    req_chan,
   lfuc_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [lfuc_pkg::CFG_W-1:0]  csr_wr_data
);

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int UW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (UW > lfuc_pkg::CFG_W) ? UW : lfuc_pkg::CFG_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

   // Entry memories: one read port (scan) and one write port each
   logic [lfuc_pkg::KEY_W-1:0] key_mem_ff   [CAPACITY];
   logic [lfuc_pkg::VAL_W-1:0] value_mem_ff [CAPACITY];
   logic [lfuc_pkg::CNT_W-1:0] count_mem_ff [CAPACITY];
   logic [IW-1:0]              rank_mem_ff  [CAPACITY];
   logic                       valid_ff     [CAPACITY];

   logic [lfuc_pkg::KEY_W-1:0] rd_key_ff;
   logic [lfuc_pkg::VAL_W-1:0] rd_value_ff;
   logic [lfuc_pkg::CNT_W-1:0] rd_count_ff;
   logic [IW-1:0]              rd_rank_ff;

   lfuc_pkg::state_type        state_ff, state_in;
   logic [lfuc_pkg::CFG_W-1:0] cap_ff;
   logic [UW-1:0]              used_ff;

   logic                       cmd_ff;
   logic [lfuc_pkg::KEY_W-1:0] key_ff;
   logic [lfuc_pkg::VAL_W-1:0] val_ff;

   logic [IW-1:0]              iss_idx_ff;
   logic                       iss_on_ff;
   logic [IW-1:0]              smp_idx_ff;
   logic                       smp_vld_ff;

   // Recency update left by the previous request
   logic                       pend_vld_ff, pend_vld_in;
   logic                       pend_all_ff, pend_all_in;
   logic [IW-1:0]              pend_slot_ff, pend_slot_in;
   logic [IW-1:0]              pend_old_ff, pend_old_in;

   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [lfuc_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                       rsp_evicted_ff, rsp_evicted_in;

   logic                       req_fire;
   logic                       rsp_fire;
   logic                       done_fire;
   logic                       last_smp;
   logic [IW-1:0]              rank_fix;

   lfuc_pkg::scan_ctl_type     scan_ctl;
   lfuc_pkg::scan_flags_type   scan_flags;
   logic [IW-1:0]              match_idx;
   logic [lfuc_pkg::VAL_W-1:0] match_value;
   logic [lfuc_pkg::CNT_W-1:0] match_count;
   logic [IW-1:0]              match_rank;
   logic [IW-1:0]              free_idx;
   logic [IW-1:0]              victim_idx;
   logic [IW-1:0]              victim_rank;

   // Commit controls
   logic [CMPW-1:0]            cap_eff;
   logic [IW-1:0]              wr_slot;
   logic                       wr_key_en;
   logic                       wr_val_en;
   logic                       wr_cnt_en;
   logic [lfuc_pkg::CNT_W-1:0] wr_cnt_data;
   logic                       fill_en;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_valid_ff && rsp_chan.ready;
   assign done_fire = (state_ff == lfuc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign last_smp  = smp_vld_ff && (smp_idx_ff == LAST_IDX);

   assign req_chan.ready      = (state_ff == lfuc_pkg::ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.evicted    = rsp_evicted_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfuc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = lfuc_pkg::ST_SCAN;
            end
         end
         lfuc_pkg::ST_SCAN: begin
            if (last_smp) begin
               state_in = lfuc_pkg::ST_DONE;
            end
         end
         lfuc_pkg::ST_DONE: begin
            if (done_fire) begin
               state_in = lfuc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfuc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lfuc_pkg::ST_IDLE;
         cap_ff    <= lfuc_pkg::CAP_RESET;
         iss_on_ff <= 1'b0;
         smp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         // Advance the read address one entry per cycle until the last one
         if (req_fire) begin
            iss_on_ff <= 1'b1;
         end else if (iss_on_ff && (iss_idx_ff == LAST_IDX)) begin
            iss_on_ff <= 1'b0;
         end
         smp_vld_ff <= iss_on_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff     <= req_chan.command;
         key_ff     <= req_chan.key;
         val_ff     <= req_chan.value;
         iss_idx_ff <= '0;
      end else if (iss_on_ff && (iss_idx_ff != LAST_IDX)) begin
         iss_idx_ff <= iss_idx_ff + IW'(1);
      end
      smp_idx_ff <= iss_idx_ff;
   end

   // Registered memory read at the scan address
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem_ff[iss_idx_ff];
      rd_value_ff <= value_mem_ff[iss_idx_ff];
      rd_count_ff <= count_mem_ff[iss_idx_ff];
      rd_rank_ff  <= rank_mem_ff[iss_idx_ff];
   end

   // Apply the pending recency update to the sampled rank
   always_comb begin
      rank_fix = rd_rank_ff;
      if (pend_vld_ff) begin
         if (smp_idx_ff == pend_slot_ff) begin
            rank_fix = '0;
         end else if (pend_all_ff || (rd_rank_ff < pend_old_ff)) begin
            rank_fix = rd_rank_ff + IW'(1);
         end
      end
   end

   always_comb begin
      scan_ctl.clear  = req_fire;
      scan_ctl.sample = smp_vld_ff;
   end

   lfuc_scan_unit #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .smp_idx     (smp_idx_ff),
      .smp_valid   (valid_ff[smp_idx_ff]),
      .smp_key     (rd_key_ff),
      .req_key     (key_ff),
      .smp_value   (rd_value_ff),
      .smp_count   (rd_count_ff),
      .smp_rank    (rank_fix),
      .flags       (scan_flags),
      .match_idx   (match_idx),
      .match_value (match_value),
      .match_count (match_count),
      .match_rank  (match_rank),
      .free_idx    (free_idx),
      .victim_idx  (victim_idx),
      .victim_rank (victim_rank)
   );

   // Commit decision for the finished scan
   always_comb begin
      cap_eff = (CMPW'(cap_ff) > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : CMPW'(cap_ff);

      wr_slot        = match_idx;
      wr_key_en      = 1'b0;
      wr_val_en      = 1'b0;
      wr_cnt_en      = 1'b0;
      wr_cnt_data    = lfuc_pkg::COUNT_ONE;
      fill_en        = 1'b0;
      pend_vld_in    = 1'b0;
      pend_all_in    = 1'b0;
      pend_slot_in   = match_idx;
      pend_old_in    = match_rank;
      rsp_hit_in     = 1'b0;
      rsp_value_in   = '0;
      rsp_evicted_in = 1'b0;

      if (scan_flags.match) begin
         rsp_hit_in  = 1'b1;
         wr_val_en   = (cmd_ff == lfuc_pkg::CMD_PUT);
         wr_cnt_en   = 1'b1;
         wr_cnt_data = (match_count == lfuc_pkg::COUNT_MAX) ?
                       match_count : match_count + lfuc_pkg::COUNT_ONE;
         pend_vld_in = 1'b1;
         if (cmd_ff == lfuc_pkg::CMD_GET) begin
            rsp_value_in = match_value;
         end
      end else if ((cmd_ff == lfuc_pkg::CMD_PUT) && (cap_eff != '0)) begin
         if (CMPW'(used_ff) < cap_eff) begin
            // Fill a free slot; every valid entry ages by one
            if (scan_flags.free) begin
               wr_slot      = free_idx;
               fill_en      = 1'b1;
               wr_key_en    = 1'b1;
               wr_val_en    = 1'b1;
               wr_cnt_en    = 1'b1;
               pend_vld_in  = 1'b1;
               pend_all_in  = 1'b1;
               pend_slot_in = free_idx;
            end
         end else if (scan_flags.victim) begin
            // Replace the LFU entry, LRU among equal counts
            wr_slot        = victim_idx;
            wr_key_en      = 1'b1;
            wr_val_en      = 1'b1;
            wr_cnt_en      = 1'b1;
            rsp_evicted_in = 1'b1;
            pend_vld_in    = 1'b1;
            pend_slot_in   = victim_idx;
            pend_old_in    = victim_rank;
         end
      end
   end

   // Memory writes: rank write-back during the scan, entry fields at commit
   always_ff @(posedge clock) begin
      if (smp_vld_ff) begin
         rank_mem_ff[smp_idx_ff] <= rank_fix;
      end
      if (done_fire) begin
         if (wr_key_en) begin
            key_mem_ff[wr_slot] <= key_ff;
         end
         if (wr_val_en) begin
            value_mem_ff[wr_slot] <= val_ff;
         end
         if (wr_cnt_en) begin
            count_mem_ff[wr_slot] <= wr_cnt_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            valid_ff[i] <= 1'b0;
         end
         used_ff     <= '0;
         pend_vld_ff <= 1'b0;
      end else if (done_fire) begin
         if (fill_en) begin
            valid_ff[wr_slot] <= 1'b1;
            used_ff           <= used_ff + UW'(1);
         end
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         pend_all_ff  <= pend_all_in;
         pend_slot_ff <= pend_slot_in;
         pend_old_ff  <= pend_old_in;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_hit_ff     <= rsp_hit_in;
         rsp_value_ff   <= rsp_value_in;
         rsp_evicted_ff <= rsp_evicted_in;
      end
   end

endmodule

/* hw/rtl/lfuc_checker.sv */
// Port-level checks for the LFU cache table, attached by bind.
// Depends on lfuc_pkg and the top level lfu_cache_table.
module lfuc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic [lfuc_pkg::VAL_W-1:0]  rsp_read_value,
   input logic                        rsp_evicted
);

   // Reset drops any pending response
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An accepted request keeps the block busy during its scan
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a scan is running");

   // A new response appears together with the block going idle
   a_idle_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response without return to idle");

   // Only a put that missed can evict
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (!rsp_hit && (rsp_read_value == '0)))
      else $error("eviction reported on a hit or with read data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value) && $stable(rsp_evicted)))
      else $error("stalled response changed");

endmodule

bind lfu_cache_table lfuc_checker u_lfuc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_hit        (rsp_chan.hit),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_evicted    (rsp_chan.evicted)
);
